@@ design/b64enc_pkg.sv @@
// shared types, constants and the sextet-to-character mapping of the base64 encoder
`timescale 1ns / 1ps
`default_nettype none

package b64enc_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // number of real bytes in a group
    localparam logic [1:0] NB_ONE   = 2'd1;
    localparam logic [1:0] NB_TWO   = 2'd2;
    localparam logic [1:0] NB_THREE = 2'd3;

    // position of a character within its group
    localparam logic [1:0] POS_0 = 2'd0;
    localparam logic [1:0] POS_1 = 2'd1;
    localparam logic [1:0] POS_2 = 2'd2;
    localparam logic [1:0] POS_3 = 2'd3;

    // one group of up to three bytes; missing bytes are zero
    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] z;
        logic [1:0] nbytes;
        logic       last;
    } t_group;

    // standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [7:0] f_b64_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        begin
            w = {2'b00, v};
            if (v < 6'd26) begin
                c = w + 8'h41;
            end else if (v < 6'd52) begin
                c = w + 8'h47;
            end else if (v < 6'd62) begin
                c = w - 8'd4;
            end else if (v == 6'd62) begin
                c = 8'h2B;
            end else begin
                c = 8'h2F;
            end
            return c;
        end
    endfunction

endpackage

`default_nettype wire

@@ design/b64enc_if.sv @@
// valid/ready channel interfaces for raw bytes in and characters out
`timescale 1ns / 1ps
`default_nettype none

interface b64enc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64enc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_char;
    logic       final_char;

    modport source (output valid, output code_char, output final_char, input ready);
    modport sink   (input valid, input code_char, input final_char, output ready);
endinterface

`default_nettype wire

@@ design/b64enc_front.sv @@
// front end: collects bytes into groups of up to three and pushes finished groups
`timescale 1ns / 1ps
`default_nettype none

module b64enc_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    b64enc_byte_if.sink           i_in,
    input  wire                   i_q_full,
    output logic                  o_q_push,
    output b64enc_pkg::t_group    o_q_data
);

    logic [7:0] r_held0, n_held0;
    logic [7:0] r_held1, n_held1;
    logic [1:0] r_count, n_count;
    logic       w_accept;

    assign i_in.ready = ~i_q_full;
    assign w_accept   = i_in.valid & ~i_q_full;

    always_comb begin
        n_held0  = r_held0;
        n_held1  = r_held1;
        n_count  = r_count;
        o_q_push = 1'b0;
        o_q_data = '0;
        o_q_data.last = i_in.end_of_message;
        case (r_count)
            2'd0: begin
                o_q_data.x      = i_in.data_byte;
                o_q_data.nbytes = b64enc_pkg::NB_ONE;
            end
            2'd1: begin
                o_q_data.x      = r_held0;
                o_q_data.y      = i_in.data_byte;
                o_q_data.nbytes = b64enc_pkg::NB_TWO;
            end
            default: begin
                o_q_data.x      = r_held0;
                o_q_data.y      = r_held1;
                o_q_data.z      = i_in.data_byte;
                o_q_data.nbytes = b64enc_pkg::NB_THREE;
            end
        endcase
        if (w_accept) begin
            if (r_count == 2'd0 && !i_in.end_of_message) begin
                n_held0 = i_in.data_byte;
                n_count = 2'd1;
            end else if (r_count == 2'd1 && !i_in.end_of_message) begin
                n_held1 = i_in.data_byte;
                n_count = 2'd2;
            end else begin
                o_q_push = 1'b1;
                n_count  = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held0 <= n_held0;
        r_held1 <= n_held1;
    end

endmodule

`default_nettype wire

@@ design/b64enc_fifo.sv @@
// two-entry queue of byte groups between front and back
`timescale 1ns / 1ps
`default_nettype none

module b64enc_fifo (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  b64enc_pkg::t_group    i_data,
    input  wire                   i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output b64enc_pkg::t_group    o_data
);

    b64enc_pkg::t_group r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/b64enc_back.sv @@
// back end: walks a group through its four characters into the output register
`timescale 1ns / 1ps
`default_nettype none

module b64enc_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_q_valid,
    input  b64enc_pkg::t_group    i_q_data,
    output logic                  o_q_pop,
    b64enc_char_if.source         o_out
);

    b64enc_pkg::t_group r_grp;
    logic       r_have;
    logic [1:0] r_idx;
    logic       r_ovalid;
    logic [7:0] r_char;
    logic       r_final;

    logic       w_adv;
    logic [5:0] w_sextet;
    logic       w_pad;
    logic [7:0] w_char;
    logic       w_final;

    assign w_adv   = r_have & (~r_ovalid | o_out.ready);
    assign o_q_pop = i_q_valid & (~r_have | (w_adv & (r_idx == b64enc_pkg::POS_3)));

    always_comb begin
        case (r_idx)
            b64enc_pkg::POS_0: w_sextet = r_grp.x[7:2];
            b64enc_pkg::POS_1: w_sextet = {r_grp.x[1:0], r_grp.y[7:4]};
            b64enc_pkg::POS_2: w_sextet = {r_grp.y[3:0], r_grp.z[7:6]};
            default:           w_sextet = r_grp.z[5:0];
        endcase
        w_pad = ((r_idx == b64enc_pkg::POS_2) && (r_grp.nbytes == b64enc_pkg::NB_ONE)) ||
                ((r_idx == b64enc_pkg::POS_3) && (r_grp.nbytes != b64enc_pkg::NB_THREE));
        w_char  = w_pad ? b64enc_pkg::PAD_CHAR : b64enc_pkg::f_b64_char(w_sextet);
        w_final = (r_idx == b64enc_pkg::POS_3) & r_grp.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_idx    <= b64enc_pkg::POS_0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_have <= 1'b1;
                r_idx  <= b64enc_pkg::POS_0;
            end else if (w_adv) begin
                r_idx <= r_idx + 2'd1;
                if (r_idx == b64enc_pkg::POS_3) begin
                    r_have <= 1'b0;
                end
            end
            if (w_adv) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_grp <= i_q_data;
        end
        if (w_adv) begin
            r_char  <= w_char;
            r_final <= w_final;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.code_char  = r_char;
    assign o_out.final_char = r_final;

endmodule

`default_nettype wire

@@ design/base64_stream_encoder.sv @@
// top level of the streaming base64 encoder
//
// usage:
//   i_in  : byte requests (data_byte, end_of_message), valid/ready handshake
//   o_out : character requests (code_char, final_char), valid/ready handshake
// the front collects bytes; every third byte, or any byte flagged as end of
// message, closes a group that goes into a two-entry queue. the back expands
// each group into four characters, one per cycle while the receiver is
// ready, through a single output register; short groups are padded with '='
// and the fourth character of a message-ending group carries final_char.
// path: the byte that closes a group is written into the queue, the group is
// then loaded into the back end's group register, and its characters are
// registered in the output register. throughput: the output register moves
// one character per cycle while the receiver is ready; the queue lets the
// front take in new bytes while the back is still expanding a group. bytes
// that only get held are accepted every cycle while the queue has room.
// reset: synchronous active-low i_rst_n empties the held bytes, the queue
// and the output register.
// receiver stall: the output holds its character; the queue fills, then
// i_in.ready drops until a group is taken by the back end.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder (
    input  wire             i_clk,
    input  wire             i_rst_n,
    b64enc_byte_if.sink     i_in,
    b64enc_char_if.source   o_out
);

    logic               w_q_full;
    logic               w_q_push;
    b64enc_pkg::t_group w_q_wdata;
    logic               w_q_pop;
    logic               w_q_valid;
    b64enc_pkg::t_group w_q_rdata;

    // byte collection and group classification
    b64enc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_data (w_q_wdata)
    );

    // decouples byte intake from character output
    b64enc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_rdata)
    );

    // character sequencing and output register
    b64enc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_rdata),
        .o_q_pop   (w_q_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
